// ===== hw/rtl/vsl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsl_pkg
// Shared widths, types and constants of the velocity slew limiter.
// ----------------------------------------------------------------------------
package vsl_pkg;

  localparam int VEL_W  = 16;                  // signed Q8.8 velocity
  localparam int DIF_W  = VEL_W + 1;           // target - current
  localparam int MAG_W  = VEL_W;               // |difference|, at most 65535
  localparam int ACC_W  = 15;                  // unsigned Q7.8 acceleration
  localparam int STEP_W = 16;                  // unsigned Q0.16 step time
  localparam int C_W    = ACC_W + STEP_W;      // allowed change, Q7.24
  localparam int SQ_W   = 2 * MAG_W;           // one squared component
  localparam int S_W    = SQ_W + 2;            // sum of three squares
  localparam int RAD_W  = S_W + 16;            // radicand, Q18.32
  localparam int ROOT_W = (RAD_W + 1) / 2;     // distance, Q9.16
  localparam int PROD_W = MAG_W + C_W;         // |d| * C
  localparam int NUM_W  = PROD_W - 8;          // dividend after the 2^8 of den
  localparam int Q_W    = MAG_W;               // quotient is below |d|

  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(1092);

  typedef logic signed [VEL_W-1:0] vel_t;

  // context carried alongside the distance computation
  typedef struct packed {
    vel_t             cur_x;
    vel_t             cur_y;
    vel_t             cur_z;
    vel_t             tgt_x;
    vel_t             tgt_y;
    vel_t             tgt_z;
    logic [MAG_W-1:0] mag_x;
    logic [MAG_W-1:0] mag_y;
    logic [MAG_W-1:0] mag_z;
    logic             neg_x;
    logic             neg_y;
    logic             neg_z;
    logic [C_W-1:0]   c;
    logic             three_d;
    logic             rec_out;
    logic             wake;
  } ctx_t;

  // context carried alongside the divider lanes
  typedef struct packed {
    vel_t cur_x;
    vel_t cur_y;
    vel_t cur_z;
    vel_t tgt_x;
    vel_t tgt_y;
    vel_t tgt_z;
    logic neg_x;
    logic neg_y;
    logic neg_z;
    logic three_d;
    logic rec_out;
    logic wake;
    logic take_tgt;
  } fin_t;

  // one result request
  typedef struct packed {
    vel_t new_vx;
    vel_t new_vy;
    vel_t new_vz;
    logic recovering_out;
    logic wake;
  } res_t;

endpackage

// ===== hw/rtl/vsl_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsl_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module vsl_sqrt
  import vsl_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [RAD_W-1:0]  rad_i,
  output logic [ROOT_W-1:0] root_o
);

  localparam int RW = RAD_W + 2;

  logic [RW-1:0]     rem_r  [ROOT_W-1];
  logic [ROOT_W-1:0] root_r [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam int B = ROOT_W - 1 - k;

    logic [RW-1:0]     rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [RW-1:0]     trial;
    logic              fit;

    if (k == 0) begin : g_first
      assign rem_in  = RW'(rad_i);
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
    end

    // (root + 2^B)^2 - root^2
    assign trial = (RW'(root_in) << (B + 1)) + (RW'(1) << (2 * B));
    assign fit   = (rem_in >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[k] <= fit ? (root_in | (ROOT_W'(1) << B)) : root_in;
      end
    end

    if (k < ROOT_W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= fit ? (rem_in - trial) : rem_in;
        end
      end
    end
  end

  assign root_o = root_r[ROOT_W-1];

endmodule

// ===== hw/rtl/vsl_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsl_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module vsl_div
  import vsl_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [ROOT_W-1:0] den_i,
  output logic [Q_W-1:0]    quo_o
);

  localparam int RW = NUM_W + 2;

  logic [RW-1:0]     rem_r [Q_W-1];
  logic [ROOT_W-1:0] den_r [Q_W-1];
  logic [Q_W-1:0]    quo_r [Q_W];

  // valid only when the quotient is known to fit Q_W bits
  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    localparam int B = Q_W - 1 - k;

    logic [RW-1:0]     rem_in;
    logic [ROOT_W-1:0] den_in;
    logic [Q_W-1:0]    quo_in;
    logic [RW-1:0]     trial;
    logic              fit;

    if (k == 0) begin : g_first
      assign rem_in = RW'(num_i);
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign quo_in = quo_r[k-1];
    end

    assign trial = RW'(den_in) << B;
    assign fit   = (rem_in >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[k] <= fit ? (quo_in | (Q_W'(1) << B)) : quo_in;
      end
    end

    if (k < Q_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= fit ? (rem_in - trial) : rem_in;
          den_r[k] <= den_in;
        end
      end
    end
  end

  assign quo_o = quo_r[Q_W-1];

endmodule

// ===== hw/rtl/vsl_obuf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsl_obuf
// Output register with a one-entry skid; stalls the pipeline when full.
// ----------------------------------------------------------------------------
module vsl_obuf
  import vsl_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic pipe_valid,
  input  res_t pipe_data,
  output logic pipe_en,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_data
);

  logic out_v_r;
  res_t out_d_r;
  logic skid_v_r;
  res_t skid_d_r;

  assign pipe_en   = !skid_v_r;
  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_ready) begin
        out_d_r  <= skid_d_r;
        skid_v_r <= 1'b0;
      end
    end else if (pipe_valid) begin
      if (!out_v_r || out_ready) begin
        out_v_r <= 1'b1;
        out_d_r <= pipe_data;
      end else begin
        skid_v_r <= 1'b1;
        skid_d_r <= pipe_data;
      end
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

endmodule

// ===== hw/rtl/velocity_slew_limiter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// velocity_slew_limiter
// Per-body vector rate limiter: steers velocity toward a target by at most
// accel_limit * step_length along the straight line.
// ----------------------------------------------------------------------------
// Takes one request per clock while in_ready is high and returns one result
// per request, in order. The pipeline depth is set by the 25-stage square
// root (one distance bit per stage) and the three 16-stage divider lanes
// (one quotient bit per stage), plus difference, square, sum, scale and
// output registers. The whole pipeline moves together; a one-entry skid
// behind the output register holds a finished result when out_ready is low,
// and in_ready drops only while that skid is occupied. step_length may be
// rewritten through cfg_we / cfg_wdata while no request is in flight; it
// resets to 1092 (about 1/60 s in Q0.16).
// ----------------------------------------------------------------------------
module velocity_slew_limiter
  import vsl_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,

  input  logic             cfg_we,
  input  logic [STEP_W-1:0] cfg_wdata,

  input  logic             in_valid,
  output logic             in_ready,
  input  logic signed [VEL_W-1:0] in_target_vx,
  input  logic signed [VEL_W-1:0] in_target_vy,
  input  logic signed [VEL_W-1:0] in_target_vz,
  input  logic signed [VEL_W-1:0] in_current_vx,
  input  logic signed [VEL_W-1:0] in_current_vy,
  input  logic signed [VEL_W-1:0] in_current_vz,
  input  logic [ACC_W-1:0] in_accel_limit,
  input  logic             in_three_d_mode,
  input  logic             in_steer_enabled,
  input  logic             in_recovering_in,
  input  logic             in_on_ground,

  output logic             out_valid,
  input  logic             out_ready,
  output logic signed [VEL_W-1:0] out_new_vx,
  output logic signed [VEL_W-1:0] out_new_vy,
  output logic signed [VEL_W-1:0] out_new_vz,
  output logic             out_recovering_out,
  output logic             out_wake
);

  // global advance: the pipeline moves whenever the skid is empty
  logic pipe_en;

  logic [STEP_W-1:0] step_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_len_r <= STEP_RESET;
    end else if (cfg_we) begin
      step_len_r <= cfg_wdata;
    end
  end

  assign in_ready = pipe_en;

  // ---------------- stage 1: differences, magnitudes, allowed change -------
  logic signed [DIF_W-1:0] dx, dy, dz;
  logic [DIF_W-1:0]        ax, ay, az;
  logic                    rec_hold;
  ctx_t                    s1_nxt;
  ctx_t                    s1_r;
  logic                    s1_v_r;

  always_comb begin
    dx = DIF_W'(in_target_vx) - DIF_W'(in_current_vx);
    dz = DIF_W'(in_target_vz) - DIF_W'(in_current_vz);
    // Y only counts in 3D mode
    dy = in_three_d_mode ? (DIF_W'(in_target_vy) - DIF_W'(in_current_vy)) : '0;
    ax = dx[DIF_W-1] ? DIF_W'(-dx) : DIF_W'(dx);
    ay = dy[DIF_W-1] ? DIF_W'(-dy) : DIF_W'(dy);
    az = dz[DIF_W-1] ? DIF_W'(-dz) : DIF_W'(dz);
    // airborne recovery passes through; grounded recovery clears the flag
    rec_hold = in_recovering_in && !in_on_ground;

    s1_nxt.cur_x   = in_current_vx;
    s1_nxt.cur_y   = in_current_vy;
    s1_nxt.cur_z   = in_current_vz;
    s1_nxt.tgt_x   = in_target_vx;
    s1_nxt.tgt_y   = in_target_vy;
    s1_nxt.tgt_z   = in_target_vz;
    s1_nxt.mag_x   = ax[MAG_W-1:0];
    s1_nxt.mag_y   = ay[MAG_W-1:0];
    s1_nxt.mag_z   = az[MAG_W-1:0];
    s1_nxt.neg_x   = dx[DIF_W-1];
    s1_nxt.neg_y   = dy[DIF_W-1];
    s1_nxt.neg_z   = dz[DIF_W-1];
    s1_nxt.c       = C_W'(in_accel_limit) * C_W'(step_len_r);
    s1_nxt.three_d = in_three_d_mode;
    s1_nxt.rec_out = rec_hold;
    // provisional: cleared later if the distance is zero
    s1_nxt.wake    = !rec_hold && in_steer_enabled;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (pipe_en) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s1_r <= s1_nxt;
    end
  end

  // ---------------- stage 2: squares ---------------------------------------
  ctx_t            s2_r;
  logic            s2_v_r;
  logic [SQ_W-1:0] sqx_r, sqy_r, sqz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (pipe_en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s2_r  <= s1_r;
      sqx_r <= SQ_W'(s1_r.mag_x) * SQ_W'(s1_r.mag_x);
      sqy_r <= SQ_W'(s1_r.mag_y) * SQ_W'(s1_r.mag_y);
      sqz_r <= SQ_W'(s1_r.mag_z) * SQ_W'(s1_r.mag_z);
    end
  end

  // ---------------- stage 3: sum of squares --------------------------------
  logic [S_W-1:0] sum_nxt;
  ctx_t           s3_nxt;
  ctx_t           s3_r;
  logic           s3_v_r;
  logic [S_W-1:0] sum_r;

  always_comb begin
    sum_nxt     = S_W'(sqx_r) + S_W'(sqy_r) + S_W'(sqz_r);
    s3_nxt      = s2_r;
    s3_nxt.wake = s2_r.wake && (sum_nxt != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (pipe_en) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s3_r  <= s3_nxt;
      sum_r <= sum_nxt;
    end
  end

  // ---------------- square root, context rides alongside -------------------
  logic [ROOT_W-1:0] root;
  ctx_t              ctx_sq_r [ROOT_W];
  logic [ROOT_W-1:0] v_sq_r;

  vsl_sqrt u_sqrt (
    .clk    (clk),
    .en     (pipe_en),
    .rad_i  ({sum_r, 16'd0}),
    .root_o (root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_sq_r <= '0;
    end else if (pipe_en) begin
      v_sq_r <= {v_sq_r[ROOT_W-2:0], s3_v_r};
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      ctx_sq_r[0] <= s3_r;
      for (int i = 1; i < ROOT_W; i++) begin
        ctx_sq_r[i] <= ctx_sq_r[i-1];
      end
    end
  end

  // ---------------- scale stage: |d| * C and the take-target compare ------
  ctx_t              cq;
  fin_t              sm_nxt;
  fin_t              sm_r;
  logic              sm_v_r;
  logic [ROOT_W-1:0] den_r;
  logic [NUM_W-1:0]  num_x_r, num_y_r, num_z_r;
  logic [PROD_W-1:0] px, py, pz;

  always_comb begin
    cq = ctx_sq_r[ROOT_W-1];
    px = PROD_W'(cq.mag_x) * PROD_W'(cq.c);
    py = PROD_W'(cq.mag_y) * PROD_W'(cq.c);
    pz = PROD_W'(cq.mag_z) * PROD_W'(cq.c);

    sm_nxt.cur_x    = cq.cur_x;
    sm_nxt.cur_y    = cq.cur_y;
    sm_nxt.cur_z    = cq.cur_z;
    sm_nxt.tgt_x    = cq.tgt_x;
    sm_nxt.tgt_y    = cq.tgt_y;
    sm_nxt.tgt_z    = cq.tgt_z;
    sm_nxt.neg_x    = cq.neg_x;
    sm_nxt.neg_y    = cq.neg_y;
    sm_nxt.neg_z    = cq.neg_z;
    sm_nxt.three_d  = cq.three_d;
    sm_nxt.rec_out  = cq.rec_out;
    sm_nxt.wake     = cq.wake;
    // allowed change covers the whole distance: jump to the target
    sm_nxt.take_tgt = ((ROOT_W + 8)'(cq.c) >= {root, 8'd0});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sm_v_r <= 1'b0;
    end else if (pipe_en) begin
      sm_v_r <= v_sq_r[ROOT_W-1];
    end
  end

  // the 2^8 of the denominator is dropped from the dividend up front
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      sm_r    <= sm_nxt;
      den_r   <= root;
      num_x_r <= px[PROD_W-1:8];
      num_y_r <= py[PROD_W-1:8];
      num_z_r <= pz[PROD_W-1:8];
    end
  end

  // ---------------- divider lanes ------------------------------------------
  logic [Q_W-1:0] qx, qy, qz;
  fin_t           fin_r [Q_W];
  logic [Q_W-1:0] v_dv_r;

  vsl_div u_div_x (
    .clk   (clk),
    .en    (pipe_en),
    .num_i (num_x_r),
    .den_i (den_r),
    .quo_o (qx)
  );

  vsl_div u_div_y (
    .clk   (clk),
    .en    (pipe_en),
    .num_i (num_y_r),
    .den_i (den_r),
    .quo_o (qy)
  );

  vsl_div u_div_z (
    .clk   (clk),
    .en    (pipe_en),
    .num_i (num_z_r),
    .den_i (den_r),
    .quo_o (qz)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_dv_r <= '0;
    end else if (pipe_en) begin
      v_dv_r <= {v_dv_r[Q_W-2:0], sm_v_r};
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      fin_r[0] <= sm_r;
      for (int i = 1; i < Q_W; i++) begin
        fin_r[i] <= fin_r[i-1];
      end
    end
  end

  // ---------------- final: apply the move, saturate, select ----------------
  function automatic vel_t step_sat(vel_t cur, logic [Q_W-1:0] q, logic neg);
    logic signed [VEL_W+1:0] delta;
    logic signed [VEL_W+1:0] sum;
    vel_t                    res;
    delta = neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
    sum   = (VEL_W + 2)'(cur) + delta;
    if (sum > (VEL_W + 2)'(32767)) begin
      res = vel_t'(32767);
    end else if (sum < -(VEL_W + 2)'(32768)) begin
      res = vel_t'(-32768);
    end else begin
      res = vel_t'(sum);
    end
    return res;
  endfunction

  fin_t f;
  res_t res_nxt;

  always_comb begin
    f = fin_r[Q_W-1];
    res_nxt.recovering_out = f.rec_out;
    res_nxt.wake           = f.wake;
    if (!f.wake) begin
      res_nxt.new_vx = f.cur_x;
      res_nxt.new_vy = f.cur_y;
      res_nxt.new_vz = f.cur_z;
    end else if (f.take_tgt) begin
      res_nxt.new_vx = f.tgt_x;
      res_nxt.new_vy = f.three_d ? f.tgt_y : f.cur_y;
      res_nxt.new_vz = f.tgt_z;
    end else begin
      res_nxt.new_vx = step_sat(f.cur_x, qx, f.neg_x);
      res_nxt.new_vy = f.three_d ? step_sat(f.cur_y, qy, f.neg_y) : f.cur_y;
      res_nxt.new_vz = step_sat(f.cur_z, qz, f.neg_z);
    end
  end

  res_t out_d;

  vsl_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .pipe_valid (v_dv_r[Q_W-1]),
    .pipe_data  (res_nxt),
    .pipe_en    (pipe_en),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_d)
  );

  assign out_new_vx         = out_d.new_vx;
  assign out_new_vy         = out_d.new_vy;
  assign out_new_vz         = out_d.new_vz;
  assign out_recovering_out = out_d.recovering_out;
  assign out_wake           = out_d.wake;

  // ---------------- checks -------------------------------------------------
  // a body still in airborne recovery is never steered
  a_wake_excl_rec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_wake && out_recovering_out))
    else $error("wake and recovering_out both set");

  // the skid only fills behind a held output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    !pipe_en |-> out_valid)
    else $error("skid occupied with empty output register");

  // a stall freezes the stage-1, square-root and divider valid bits
  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    !pipe_en |=> ($stable(s1_v_r) && $stable(v_sq_r) && $stable(v_dv_r)))
    else $error("pipeline moved during stall");

  // once full, the skid drains only when the output is taken
  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (!pipe_en && !out_ready) |=> !pipe_en)
    else $error("skid dropped a result");

endmodule

// ===== tb/slew_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slew_checker
// Watches the request, result and step-length ports of the slew limiter,
// predicts each result on its own and compares it field by field.
// ----------------------------------------------------------------------------
module slew_checker
  import vsl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [STEP_W-1:0] cfg_wdata,
  input  logic              in_valid,
  input  logic              in_ready,
  input  vel_t              in_target_vx,
  input  vel_t              in_target_vy,
  input  vel_t              in_target_vz,
  input  vel_t              in_current_vx,
  input  vel_t              in_current_vy,
  input  vel_t              in_current_vz,
  input  logic [ACC_W-1:0]  in_accel_limit,
  input  logic              in_three_d_mode,
  input  logic              in_steer_enabled,
  input  logic              in_recovering_in,
  input  logic              in_on_ground,
  input  logic              out_valid,
  input  logic              out_ready,
  input  vel_t              out_new_vx,
  input  vel_t              out_new_vy,
  input  vel_t              out_new_vz,
  input  logic              out_recovering_out,
  input  logic              out_wake,
  output int                mismatch_count,
  output int                pending_reqs
);

  logic [STEP_W-1:0] step_q;
  res_t              expected_velocities [$];
  res_t              want;

  function automatic longint int_sqrt(longint n);
    longint root;
    longint probe;
    root  = 0;
    probe = longint'(1) << 62;
    while (probe > n) probe = probe >> 2;
    while (probe != 0) begin
      if (n >= root + probe) begin
        n    = n - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  function automatic vel_t clamp_vel(longint v);
    if (v > 32767) return vel_t'(32767);
    if (v < -32768) return vel_t'(-32768);
    return vel_t'(v);
  endfunction

  // move toward target, magnitude truncated toward zero
  function automatic longint scaled_move(longint d, longint c, longint den);
    longint q;
    q = ((d < 0) ? -d : d) * c / den;
    return (d < 0) ? -q : q;
  endfunction

  function automatic res_t limit_velocity(vel_t tx, vel_t ty, vel_t tz,
                                          vel_t cx, vel_t cy, vel_t cz,
                                          logic [ACC_W-1:0] accel,
                                          logic td, logic st, logic rec,
                                          logic gnd, logic [STEP_W-1:0] step);
    res_t   r;
    longint dx, dy, dz, sq, den, c;
    r.new_vx         = cx;
    r.new_vy         = cy;
    r.new_vz         = cz;
    r.recovering_out = rec;
    r.wake           = 1'b0;
    if (!(rec && !gnd)) begin
      r.recovering_out = 1'b0;
      if (st) begin
        dx = longint'(tx) - longint'(cx);
        dz = longint'(tz) - longint'(cz);
        dy = td ? longint'(ty) - longint'(cy) : 0;
        sq = dx * dx + dy * dy + dz * dz;
        if (sq != 0) begin
          den    = int_sqrt(sq << 16) << 8;
          c      = longint'(accel) * longint'(step);
          r.wake = 1'b1;
          if (c >= den) begin
            r.new_vx = tx;
            r.new_vz = tz;
            if (td) r.new_vy = ty;
          end else begin
            r.new_vx = clamp_vel(longint'(cx) + scaled_move(dx, c, den));
            r.new_vz = clamp_vel(longint'(cz) + scaled_move(dz, c, den));
            if (td) r.new_vy = clamp_vel(longint'(cy) + scaled_move(dy, c, den));
          end
        end
      end
    end
    return r;
  endfunction

  task automatic check_field(string field_name, int want_val, int got_val);
    if (want_val != got_val) begin
      mismatch_count++;
      $display("%0t: %s expected %0d, got %0d", $time, field_name, want_val, got_val);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_velocities.delete();
      step_q       = STEP_RESET;
      pending_reqs <= 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_velocities.push_back(limit_velocity(
          in_target_vx, in_target_vy, in_target_vz,
          in_current_vx, in_current_vy, in_current_vz, in_accel_limit,
          in_three_d_mode, in_steer_enabled, in_recovering_in, in_on_ground,
          step_q));
      end
      if (out_valid && out_ready) begin
        if (expected_velocities.size() == 0) begin
          mismatch_count++;
          $display("%0t: result expected none, got vx %0d vy %0d vz %0d rec %0b wake %0b",
                   $time, out_new_vx, out_new_vy, out_new_vz, out_recovering_out,
                   out_wake);
        end else begin
          want = expected_velocities.pop_front();
          check_field("new_vx", want.new_vx, out_new_vx);
          check_field("new_vy", want.new_vy, out_new_vy);
          check_field("new_vz", want.new_vz, out_new_vz);
          check_field("recovering_out", want.recovering_out, out_recovering_out);
          check_field("wake", want.wake, out_wake);
        end
      end
      if (cfg_we) step_q = cfg_wdata;
      pending_reqs <= expected_velocities.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the velocity slew limiter with directed corner requests and shaped
// random requests over several step lengths and back-pressure patterns; the
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import vsl_pkg::*;

  localparam int VEL_MAX      = 32767;
  localparam int VEL_MIN      = -32768;
  localparam int ACC_NOMINAL  = 25600;   // 100 blocks/s^2, top of normal range
  localparam int PIPE_LATENCY = 46;      // request to result, no stall
  localparam int SETTLE_CYCLES = 64;     // quiet time after the last result
  localparam int CYCLE_LIMIT  = 200000;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [STEP_W-1:0] cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  vel_t              in_target_vx = '0;
  vel_t              in_target_vy = '0;
  vel_t              in_target_vz = '0;
  vel_t              in_current_vx = '0;
  vel_t              in_current_vy = '0;
  vel_t              in_current_vz = '0;
  logic [ACC_W-1:0]  in_accel_limit = '0;
  logic              in_three_d_mode = 1'b0;
  logic              in_steer_enabled = 1'b0;
  logic              in_recovering_in = 1'b0;
  logic              in_on_ground = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  vel_t              out_new_vx;
  vel_t              out_new_vy;
  vel_t              out_new_vz;
  logic              out_recovering_out;
  logic              out_wake;

  int mismatch_count;
  int pending_reqs;
  int cycle_count;

  // idle percentages of the current phase
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  velocity_slew_limiter u_dut (.*);

  slew_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard stop if the run hangs
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // result side: random stalls, rate set per phase
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Present one request; holds it until the handshake. Returns in the time
  // step of the accepting edge with in_valid still high, so the next request
  // can follow back to back.
  task automatic send_request(input vel_t tx, input vel_t ty, input vel_t tz,
                              input vel_t cx, input vel_t cy, input vel_t cz,
                              input logic [ACC_W-1:0] acc, input logic td,
                              input logic st, input logic rec, input logic gnd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_target_vx     <= tx;
    in_target_vy     <= ty;
    in_target_vz     <= tz;
    in_current_vx    <= cx;
    in_current_vy    <= cy;
    in_current_vz    <= cz;
    in_accel_limit   <= acc;
    in_three_d_mode  <= td;
    in_steer_enabled <= st;
    in_recovering_in <= rec;
    in_on_ground     <= gnd;
    in_valid         <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop sending and wait until every predicted result has been taken.
  // pending_reqs is registered in the checker, so it lags the queue size by one register.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_reqs != 0);
  endtask

  // step_length only changes with the pipeline empty
  task automatic write_step(input logic [STEP_W-1:0] value);
    drain_results();
    repeat (PIPE_LATENCY) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic vel_t corner_vel();
    case ($urandom_range(5))
      0:       return vel_t'(VEL_MIN);
      1:       return vel_t'(VEL_MAX);
      2:       return vel_t'(0);
      3:       return vel_t'(-1);
      4:       return vel_t'(1);
      default: return vel_t'(256);
    endcase
  endfunction

  // Random request. Nearly half of the targets sit near the current velocity
  // so that partial moves and full snaps to the target both show up; the
  // rest are fully random, corner values, or differ only in y (zero in 2D).
  task automatic send_random_request();
    vel_t             cur [3];
    vel_t             tgt [3];
    logic [ACC_W-1:0] acc;
    int               style;
    int               span;
    int               k;
    int               pick;
    style = $urandom_range(99);
    for (k = 0; k < 3; k++) begin
      cur[k] = vel_t'($urandom);
      if (style < 45) begin
        span   = 1 << $urandom_range(12);
        tgt[k] = vel_t'(int'(cur[k]) + int'($urandom_range(2 * span)) - span);
      end else if (style < 70) begin
        tgt[k] = vel_t'($urandom);
      end else if (style < 85) begin
        cur[k] = corner_vel();
        tgt[k] = corner_vel();
      end else begin
        tgt[k] = (k == 1) ? vel_t'($urandom) : cur[k];  // y differs: 2D sees zero
      end
    end
    pick = $urandom_range(9);
    if (pick < 7) acc = ACC_W'($urandom_range(ACC_NOMINAL, 1));
    else if (pick == 7) acc = ACC_W'($urandom_range(63, 1));
    else acc = ACC_W'($urandom_range((1 << ACC_W) - 1));
    send_request(tgt[0], tgt[1], tgt[2], cur[0], cur[1], cur[2], acc,
                 1'($urandom_range(1)), $urandom_range(99) < 88,
                 $urandom_range(99) < 25, 1'($urandom_range(1)));
  endtask

  // One phase of random traffic; halfway through the sender holds off until
  // the pipeline has fully drained.
  task automatic run_phase(input int count, input int send_pct, input int recv_pct);
    int i;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    for (i = 0; i < count; i++) begin
      if (i == count / 2) drain_results();
      send_random_request();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests at the reset step length.
    // args: target x,y,z  current x,y,z  accel  3d steer recovering grounded
    send_request(0, 0, 0, 0, 0, 0, 256, 1, 1, 0, 0);              // zero distance
    send_request(512, 0, -512, 0, 0, 0, 256, 0, 0, 0, 0);         // steering off
    send_request(1000, 0, 1000, 0, 0, 0, ACC_NOMINAL, 1, 1, 1, 0); // airborne recovery
    send_request(1000, 200, 1000, 0, 0, 0, ACC_NOMINAL, 1, 1, 1, 1); // grounded recovery
    send_request(0, VEL_MAX, 0, 0, VEL_MIN, 0, ACC_NOMINAL, 0, 1, 0, 0); // 2D ignores y
    send_request(VEL_MAX, VEL_MAX, VEL_MAX, VEL_MIN, VEL_MIN, VEL_MIN,
                 ACC_NOMINAL, 1, 1, 0, 1);                        // widest 3D span
    send_request(VEL_MIN, VEL_MIN, VEL_MIN, VEL_MAX, VEL_MAX, VEL_MAX,
                 (1 << ACC_W) - 1, 1, 1, 0, 0);                   // reverse, max accel
    send_request(1, 0, 0, 0, 0, 0, 1, 0, 1, 0, 0);                // move rounds to nothing
    send_request(-3000, 100, 2000, 500, 0, -700, 0, 1, 1, 0, 0);  // zero acceleration
    send_request(10, -5, 3, 0, 0, 0, ACC_NOMINAL, 1, 1, 0, 0);    // snaps to target
    send_request(-2560, 0, 1280, 2560, 0, -1280, ACC_NOMINAL, 0, 1, 0, 1);
    send_request(VEL_MAX, 0, VEL_MIN, 0, 0, 0, (1 << ACC_W) - 1, 0, 1, 0, 0);
    send_request(0, 0, 0, VEL_MIN, VEL_MAX, -1, 16384, 1, 1, 0, 0);
    send_request(VEL_MIN, 0, VEL_MAX, VEL_MIN, 0, VEL_MAX, 100, 1, 1, 1, 1); // leaves recovery, no move
    send_request(300, -300, 300, -300, 300, -300, 1, 1, 0, 1, 1); // grounded recovery, no steer

    // Random phases: step length and back-pressure vary per phase.
    run_phase(200, 0, 0);
    write_step(16'hFFFF);                 // longest step
    run_phase(250, 87, 0);
    write_step(16'h0001);                 // shortest step
    run_phase(250, 0, 87);
    write_step(STEP_W'($urandom_range(16'hFFFF, 1)));
    run_phase(300, 18, 18);
    write_step(STEP_W'($urandom_range(16'hFFFF, 1)));
    run_phase(250, 0, 0);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/vsl_pkg.sv
hw/rtl/vsl_sqrt.sv
hw/rtl/vsl_div.sv
hw/rtl/vsl_obuf.sv
hw/rtl/velocity_slew_limiter.sv
tb/slew_checker.sv
tb/testbench.sv
